// ===== rtl/core/aas_pkg.sv =====
// ----------------------------------------------------------------------------
// aas_pkg
// Shared types, widths and the arctangent table for the axle steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package aas_pkg;

  localparam int DEFAULT_ITER = 16;
  localparam int ITER_MAX     = 24;

  localparam int VW     = 23;  // velocity width
  localparam int QW     = 31;  // radius quotient width
  localparam int CW     = 52;  // cordic x/y width
  localparam int ZW     = 32;  // cordic angle width, Q2.30
  localparam int AW     = 18;  // output angle width
  localparam int CFG_DW = 21;

  localparam logic [1:0] REG_AXLE_OFFSET    = 2'd0;
  localparam logic [1:0] REG_TRACK_WIDTH    = 2'd1;
  localparam logic [1:0] REG_REAR_AXLE      = 2'd2;
  localparam logic [1:0] REG_ZERO_THRESHOLD = 2'd3;

  localparam logic signed [AW-1:0] ANGLE_MAX = 18'sd102944;

  typedef struct packed {
    logic valid;
    logic straight;
    logic wpos;
  } tag_t;

  typedef struct packed {
    tag_t          tag;
    logic          ovf;
    logic [VW-1:0] rem;
    logic [VW-1:0] den;
    logic [QW-1:0] num;
    logic [QW-1:0] q;
  } div_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 32'sd843314857;
      1:  a = 32'sd497837829;
      2:  a = 32'sd263043837;
      3:  a = 32'sd133525159;
      4:  a = 32'sd67021687;
      5:  a = 32'sd33543516;
      6:  a = 32'sd16775851;
      7:  a = 32'sd8388437;
      8:  a = 32'sd4194283;
      9:  a = 32'sd2097149;
      10: a = 32'sd1048576;
      11: a = 32'sd524288;
      12: a = 32'sd262144;
      13: a = 32'sd131072;
      14: a = 32'sd65536;
      15: a = 32'sd32768;
      16: a = 32'sd16384;
      17: a = 32'sd8192;
      18: a = 32'sd4096;
      19: a = 32'sd2048;
      20: a = 32'sd1024;
      21: a = 32'sd512;
      22: a = 32'sd256;
      23: a = 32'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/aas_div_cell.sv =====
// ----------------------------------------------------------------------------
// aas_div_cell
// One restoring division step: shifts in a numerator bit, yields a quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module aas_div_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire aas_pkg::div_t d,
  output aas_pkg::div_t      q
);

  logic [aas_pkg::VW:0] sh;
  logic                 ge;
  aas_pkg::div_t        q_next;

  always_comb begin
    sh = {d.rem, d.num[aas_pkg::QW-1]};
    ge = sh >= {1'b0, d.den};
    q_next = d;
    q_next.tag.valid = d.tag.valid && !rst;
    q_next.rem = ge ? aas_pkg::VW'(sh - {1'b0, d.den}) : sh[aas_pkg::VW-1:0];
    q_next.num = {d.num[aas_pkg::QW-2:0], 1'b0};
    q_next.q = {d.q[aas_pkg::QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

`default_nettype wire

// ===== rtl/core/aas_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// aas_cordic_cell
// One vectoring CORDIC micro-rotation at a fixed shift.
// ----------------------------------------------------------------------------
`default_nettype none

module aas_cordic_cell #(
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire aas_pkg::vec_t d,
  output aas_pkg::vec_t      q
);

  localparam logic signed [aas_pkg::ZW-1:0] ANG = aas_pkg::atan_q30(IDX);

  logic signed [aas_pkg::CW-1:0] dx;
  logic signed [aas_pkg::CW-1:0] dy;

  always_comb begin
    dx = d.y >>> IDX;
    dy = d.x >>> IDX;
  end

  always_ff @(posedge clk) begin
    if (!d.y[aas_pkg::CW-1]) begin
      q.x <= d.x + dx;
      q.y <= d.y - dy;
      q.z <= d.z + ANG;
    end else begin
      q.x <= d.x - dx;
      q.y <= d.y + dy;
      q.z <= d.z - ANG;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ackermann_axle_steering_angle.sv =====
// ----------------------------------------------------------------------------
// ackermann_axle_steering_angle
// Steering angle of one axle from a commanded linear and angular velocity.
// ----------------------------------------------------------------------------
// N = min(ATAN_ITERATIONS, 24) sets the length of each CORDIC chain.
// Throughput: one word per cycle; busy is always low.
// Path: input stage, 31-cell radius divider, radius stage, two N-cell CORDIC chains, output.
// Reset: synchronous, clears pipeline valids and loads register defaults.
// Results cannot be stalled.
`default_nettype none

module ackermann_axle_steering_angle #(
  parameter int ATAN_ITERATIONS = aas_pkg::DEFAULT_ITER
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [22:0]        speed,
  input  wire logic signed [22:0]        yaw_rate,
  output logic                           done,
  output logic signed [17:0]             steering_angle,
  output logic                           straight,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [aas_pkg::CFG_DW-1:0] cfg_data
);

  localparam int NI = (ATAN_ITERATIONS > aas_pkg::ITER_MAX) ? aas_pkg::ITER_MAX
                                                            : ATAN_ITERATIONS;

  logic signed [20:0] axle_pos;
  logic [19:0]        wheel_track;
  logic               rear_axle;
  logic [16:0]        zero_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      axle_pos       <= 21'sd16384;
      wheel_track    <= 20'd32768;
      rear_axle      <= 1'b0;
      zero_threshold <= 17'd65;
    end else if (cfg_we) begin
      case (cfg_index)
        aas_pkg::REG_AXLE_OFFSET:    axle_pos <= $signed(cfg_data);
        aas_pkg::REG_TRACK_WIDTH:    wheel_track <= cfg_data[19:0];
        aas_pkg::REG_REAR_AXLE:      rear_axle <= cfg_data[0];
        aas_pkg::REG_ZERO_THRESHOLD: zero_threshold <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input stage
  logic [22:0]   av;
  logic [22:0]   aw;
  aas_pkg::div_t d0_next;
  aas_pkg::div_t dv [0:31];

  always_comb begin
    av = speed[22] ? 23'(-speed) : speed;
    aw = yaw_rate[22] ? 23'(-yaw_rate) : yaw_rate;
    d0_next.tag.valid = start && !rst;
    d0_next.tag.straight = (aw < {6'd0, zero_threshold}) || (aw == '0);
    d0_next.tag.wpos = !yaw_rate[22] && (yaw_rate != '0);
    d0_next.ovf = {15'd0, av[22:15]} >= aw;
    d0_next.rem = {15'd0, av[22:15]};
    d0_next.den = aw;
    d0_next.num = {av[14:0], 16'd0};
    d0_next.q = '0;
  end

  always_ff @(posedge clk) begin
    dv[0] <= d0_next;
  end

  for (genvar k = 0; k < 31; k++) begin : g_div
    aas_div_cell u_div (.clk(clk), .rst(rst), .d(dv[k]), .q(dv[k+1]));
  end

  // radius stage
  logic [30:0]        r;
  logic [18:0]        half;
  logic signed [32:0] r_in;
  logic signed [32:0] r_in_c;
  logic [32:0]        r_out;
  aas_pkg::vec_t      vin [0:NI];
  aas_pkg::vec_t      vout [0:NI];
  aas_pkg::tag_t      tag [0:NI];

  always_comb begin
    r = dv[31].ovf ? 31'h7FFFFFFF : dv[31].q;
    half = wheel_track[19:1];
    r_in = $signed({2'b0, r}) - $signed({14'b0, half});
    r_in_c = (r_in < $signed({16'b0, zero_threshold})) ? $signed({16'b0, zero_threshold})
                                                        : r_in;
    r_out = {2'b0, r} + {14'b0, half};
  end

  always_ff @(posedge clk) begin
    vin[0].x <= $signed({3'b0, r_in_c, 16'd0});
    vin[0].y <= $signed({{15{axle_pos[20]}}, axle_pos, 16'd0});
    vin[0].z <= '0;
    vout[0].x <= $signed({3'b0, r_out, 16'd0});
    vout[0].y <= $signed({{15{axle_pos[20]}}, axle_pos, 16'd0});
    vout[0].z <= '0;
    if (rst) begin
      tag[0] <= '0;
    end else begin
      tag[0] <= dv[31].tag;
    end
  end

  for (genvar j = 0; j < NI; j++) begin : g_cordic
    aas_cordic_cell #(.IDX(j)) u_in  (.clk(clk), .d(vin[j]),  .q(vin[j+1]));
    aas_cordic_cell #(.IDX(j)) u_out (.clk(clk), .d(vout[j]), .q(vout[j+1]));
    always_ff @(posedge clk) begin
      if (rst) begin
        tag[j+1] <= '0;
      end else begin
        tag[j+1] <= tag[j];
      end
    end
  end

  // output stage
  logic signed [32:0] sum;
  logic signed [33:0] rnd;
  logic signed [18:0] base;
  logic signed [19:0] ang;
  logic               neg;
  logic signed [17:0] ang_sat;

  always_comb begin
    if (axle_pos == '0) begin
      sum = '0;
    end else begin
      sum = 33'(vin[NI].z) + 33'(vout[NI].z);
    end
    rnd = 34'(sum) + 34'sd16384;
    base = 19'(rnd >>> 15);
    neg = rear_axle ? tag[NI].wpos : !tag[NI].wpos;
    ang = neg ? -20'(base) : 20'(base);
    if (ang > 20'(aas_pkg::ANGLE_MAX)) begin
      ang_sat = aas_pkg::ANGLE_MAX;
    end else if (ang < -20'(aas_pkg::ANGLE_MAX)) begin
      ang_sat = -aas_pkg::ANGLE_MAX;
    end else begin
      ang_sat = ang[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag[NI].valid;
    end
    straight <= tag[NI].straight;
    steering_angle <= tag[NI].straight ? '0 : ang_sat;
  end

endmodule

`default_nettype wire

// ===== rtl/core/aas_checker.sv =====
// ----------------------------------------------------------------------------
// aas_checker
// Port-level checks on the steering angle block.
// ----------------------------------------------------------------------------
`default_nettype none

module aas_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               busy,
  input wire logic               done,
  input wire logic signed [17:0] steering_angle,
  input wire logic               straight
);

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy asserted");

  a_done_cleared: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");

  a_straight_zero: assert property (@(posedge clk) disable iff (rst)
    done && straight |-> steering_angle == '0)
    else $error("straight word with nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done |-> steering_angle <= aas_pkg::ANGLE_MAX && steering_angle >= -aas_pkg::ANGLE_MAX)
    else $error("angle out of range");

endmodule

bind ackermann_axle_steering_angle aas_checker u_aas_checker (
  .clk(clk),
  .rst(rst),
  .busy(busy),
  .done(done),
  .steering_angle(steering_angle),
  .straight(straight)
);

`default_nettype wire

// ===== sim/ackermann_axle_steering_angle_test.sv =====
// ----------------------------------------------------------------------------
// ackermann_axle_steering_angle_test
// Drives velocity words through the steering block under several register
// settings and random start gaps, predicts each angle with a local CORDIC
// model and checks every done word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ackermann_axle_steering_angle_test;

  localparam int ITER    = 16;
  localparam int LATENCY = 34 + ITER;

  typedef struct packed {
    logic signed [22:0] lin;
    logic signed [22:0] ang;
  } cmd_t;

  typedef struct packed {
    logic signed [17:0] angle;
    logic               flat;
  } steer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [22:0] speed = '0;
  logic signed [22:0] yaw_rate = '0;
  logic done;
  logic signed [17:0] steering_angle;
  logic straight;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = aas_pkg::REG_AXLE_OFFSET;
  logic [aas_pkg::CFG_DW-1:0] cfg_data = '0;

  ackermann_axle_steering_angle #(.ATAN_ITERATIONS(ITER)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .speed(speed), .yaw_rate(yaw_rate),
    .done(done), .steering_angle(steering_angle), .straight(straight),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the registers
  longint offset_q = 16384;
  longint track_q = 32768;
  bit rear_q = 1'b0;
  longint thresh_q = 65;

  cmd_t pending_cmds[$];
  steer_t expected_angles[$];
  int errors = 0;
  int gap = 0;
  bit feeding = 1'b0;

  function automatic longint shift_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_table(int i);
    longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    return t[i];
  endfunction

  function automatic longint vector_atan(longint y0, longint x0);
    longint x, y, z, dx, dy;
    x = x0 * 65536;
    y = y0 * 65536;
    z = 0;
    if (y0 == 0) return 0;
    for (int i = 0; i < ITER && i < 24; i++) begin
      dx = shift_floor(y, i);
      dy = shift_floor(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_table(i);
      end else begin
        x -= dx; y += dy; z -= atan_table(i);
      end
    end
    return z;
  endfunction

  function automatic steer_t steer_angle(cmd_t c);
    steer_t r;
    longint v, w, av, aw, rad, rin, rout, half, base, a;
    v = c.lin;
    w = c.ang;
    av = v < 0 ? -v : v;
    aw = w < 0 ? -w : w;
    if (aw < thresh_q || aw == 0) begin
      r.angle = '0;
      r.flat = 1'b1;
      return r;
    end
    rad = (av <<< 16) / aw;
    if (rad > 64'sd2147483647) rad = 64'sd2147483647;
    half = track_q >>> 1;
    rin = rad - half;
    if (rin < thresh_q) rin = thresh_q;
    rout = rad + half;
    base = shift_floor(vector_atan(offset_q, rin) + vector_atan(offset_q, rout) + 16384, 15);
    a = ((w > 0) ^ rear_q) ? base : -base;
    if (a > 102944) a = 102944;
    if (a < -102944) a = -102944;
    r.angle = a[17:0];
    r.flat = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      expected_angles.push_back(steer_angle({speed, yaw_rate}));
      void'(pending_cmds.pop_front());
    end
    if (rst || !feeding || pending_cmds.size() == 0) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 1) == 0) gap = 0;
      if (gap == 0) begin
        speed <= pending_cmds[0].lin;
        yaw_rate <= pending_cmds[0].ang;
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap > 0) gap--;
      if (gap == 0) begin
        start <= 1'b1;
        speed <= pending_cmds[0].lin;
        yaw_rate <= pending_cmds[0].ang;
      end
    end
  end

  always @(posedge clk) begin
    steer_t e;
    if (!rst && done) begin
      if (expected_angles.size() == 0) begin
        report_mismatch("unexpected word");
      end else begin
        e = expected_angles.pop_front();
        if (steering_angle !== e.angle)
          report_mismatch($sformatf("angle %0d, want %0d", steering_angle, e.angle));
        if (straight !== e.flat)
          report_mismatch($sformatf("straight %0b, want %0b", straight, e.flat));
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[aas_pkg::CFG_DW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      aas_pkg::REG_AXLE_OFFSET: offset_q = longint'($signed(val[20:0]));
      aas_pkg::REG_TRACK_WIDTH: track_q = val & 64'hFFFFF;
      aas_pkg::REG_REAR_AXLE: rear_q = val[0];
      aas_pkg::REG_ZERO_THRESHOLD: thresh_q = val & 64'h1FFFF;
      default: ;
    endcase
  endtask

  task automatic run_phase();
    feeding = 1'b1;
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    feeding = 1'b0;
    wait (expected_angles.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic signed [22:0] rand_vel();
    int k;
    k = $urandom_range(0, 9);
    if (k < 3) return $signed(23'($urandom_range(0, 2 * 65536))) - 65536;
    if (k < 5) return 23'($urandom);
    if (k == 5) return $urandom_range(0, 1) ? 23'sd2097151 : -23'sd2097152;
    return $signed(23'($urandom_range(0, 40 * 65536))) - 20 * 65536;
  endfunction

  task automatic add_cmd(logic signed [22:0] l, logic signed [22:0] a);
    pending_cmds.push_back({l, a});
  endtask

  initial begin
    longint offs[6];
    longint tracks[6];
    longint thrs[6];
    offs = '{16384, 0, -524288, 524287, 1048575, -65536};
    tracks = '{32768, 0, 524288, 1048575, 100000, 70000};
    thrs = '{65, 0, 65536, 131071, 1, 3000};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // directed
    add_cmd(23'sd65536, 23'sd65536);
    add_cmd(-23'sd65536, 23'sd65536);
    add_cmd(23'sd65536, -23'sd65536);
    add_cmd(23'sd2097151, 23'sd1);
    add_cmd(-23'sd2097152, -23'sd2097152);
    add_cmd(23'sd2097151, 23'sd2097151);
    add_cmd(23'sd0, 23'sd65536);
    add_cmd(23'sd65536, 23'sd0);
    add_cmd(23'sd65536, 23'sd64);
    add_cmd(23'sd65536, 23'sd65);
    add_cmd(23'sd65536, -23'sd64);
    add_cmd(23'sd1000, 23'sd2097151);
    add_cmd(-23'sd2097152, 23'sd70);
    add_cmd($signed(23'h400000), $signed(23'h400000));
    add_cmd($signed(23'h400000), 23'sd3);
    run_phase();
    write_reg(aas_pkg::REG_TRACK_WIDTH, 0);
    write_reg(aas_pkg::REG_ZERO_THRESHOLD, 0);
    write_reg(aas_pkg::REG_AXLE_OFFSET, 0);
    add_cmd(23'sd65536, 23'sd1);
    add_cmd(23'sd0, 23'sd1);
    add_cmd(23'sd0, 23'sd0);
    write_reg(aas_pkg::REG_REAR_AXLE, 1);
    run_phase();
    write_reg(aas_pkg::REG_AXLE_OFFSET, -524288);
    write_reg(aas_pkg::REG_TRACK_WIDTH, 1048575);
    add_cmd(23'sd0, 23'sd1);
    add_cmd(23'sd100, -23'sd5);
    add_cmd(23'sd65536, 23'sd65536);
    run_phase();
    for (int p = 0; p < 12; p++) begin
      write_reg(aas_pkg::REG_AXLE_OFFSET, (p < 6) ? offs[p] : $urandom_range(0, 2097151));
      write_reg(aas_pkg::REG_TRACK_WIDTH, (p < 6) ? tracks[p] : $urandom_range(0, 1048575));
      write_reg(aas_pkg::REG_REAR_AXLE, (p == 11) ? 3 : p & 1);
      write_reg(aas_pkg::REG_ZERO_THRESHOLD, thrs[p % 6]);
      for (int n = 0; n < 145; n++) add_cmd(rand_vel(), rand_vel());
      run_phase();
    end
    if (errors == 0) begin
      $display("ackermann_axle_steering_angle_test: PASS");
    end else begin
      $display("ackermann_axle_steering_angle_test: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("ackermann_axle_steering_angle_test: FAIL");
    $finish;
  end

endmodule
